// ----- rtl/kfrl_pkg.sv -----
package kfrl_pkg;

   localparam int MAX_KEYS_DEF   = 64;
   localparam int TIME_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int INDEX_W   = 16;
   localparam int CMD_W     = 2;
   localparam int STAT_W    = 3;
   localparam int CSR_IDX_W = 2;

   localparam longint END_TIME_RESET     = 65536;
   localparam logic [INDEX_W-1:0] COUNT_RESET = 16'd2;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_START_TIME   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_END_TIME     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_COUNT = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FEW      = 3'd2;
   localparam logic [STAT_W-1:0] STAT_CLAMP    = 3'd3;
   localparam logic [STAT_W-1:0] STAT_ZERO_SEG = 3'd4;

   typedef enum logic [2:0] {
      SEL_RANGE,
      SEL_FEW,
      SEL_ABOVE,
      SEL_FOUND,
      SEL_DIV
   } out_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_TSTART,
      S_DIV_T,
      S_TIME,
      S_SCAN0,
      S_SCAN,
      S_FCHK,
      S_DIV_F,
      S_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic        key_clear;
      logic        key_append;
      logic        load_query;
      logic        mul_go;
      logic        div_time;
      logic        time_go;
      logic        scan_first;
      logic        scan_step;
      logic        div_frac;
      logic        out_load;
      out_sel_type out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic bad_index;
      logic few_keys;
      logic div_done;
      logic scan_found;
      logic scan_end;
      logic frac_direct;
   } dp_stat_type;

endpackage

// ----- rtl/keyframe_uniform_resample_locator.sv -----
// Keyframe table with evenly spaced resample lookup.
// req channel: tuser carries the command (clear table, append key, query sample),
// tdata carries key_time and sample_index. Clear and append give no item on
// rsp; an append to a full table is dropped.
// A query gives one rsp item: segment_index, fraction, sample_time and status.
// A query runs, as needed, a 16-bit index times the time span, a serial divide
// by output_count-1 at one bit per cycle over TIME_WIDTH + 16 dividend bits, a
// key table scan at one key per cycle from a RAM with separate read and write
// ports, and a serial divide for the FRAC_BITS fraction bits. One query is in
// flight at a time; the next one is taken in the cycle after the result is
// loaded.
// rsp has an output register: a finished item waits there while rsp_tready is
// low, and the next item is still accepted and worked on; a second result
// waits in the last step until the register is free.
// csr writes set start_time, end_time and output_count and are always ready;
// write them only while no query is in flight.
// Synchronous reset empties the key table, restores the register defaults
// (start 0, end 1.0, count 2) and drops any pending result.
module keyframe_uniform_resample_locator #(
   parameter int MAX_KEYS   = kfrl_pkg::MAX_KEYS_DEF,
   parameter int TIME_WIDTH = kfrl_pkg::TIME_WIDTH_DEF,
   parameter int FRAC_BITS  = kfrl_pkg::FRAC_BITS_DEF,
   localparam int AW     = $clog2(MAX_KEYS),
   localparam int IW     = kfrl_pkg::INDEX_W,
   localparam int FW     = FRAC_BITS + 1,
   localparam int SW     = kfrl_pkg::STAT_W,
   localparam int REQ_W  = ((TIME_WIDTH + IW + 7) / 8) * 8,
   localparam int RSP_W  = ((AW + FW + TIME_WIDTH + SW + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,  // key_time, sample_index
   input  logic [kfrl_pkg::CMD_W-1:0]        req_tuser,  // command
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // segment_index, fraction, sample_time, status
   output logic [RSP_W-1:0]                  rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kfrl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [TIME_WIDTH-1:0]             csr_data
);

   kfrl_pkg::dp_cmd_type  dp_cmd;
   kfrl_pkg::dp_stat_type dp_stat;

   logic [AW-1:0]         segment_index;
   logic [FW-1:0]         fraction;
   logic [TIME_WIDTH-1:0] sample_time;
   logic [SW-1:0]         status;

   assign csr_ready = 1'b1;

   kfrl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_command (req_tuser),
      .req_ready   (req_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .cmd         (dp_cmd),
      .stat        (dp_stat)
   );

   kfrl_dp #(
      .MAX_KEYS   (MAX_KEYS),
      .TIME_WIDTH (TIME_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .stat              (dp_stat),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_key_time      (req_tdata[TIME_WIDTH-1:0]),
      .req_sample_index  (req_tdata[TIME_WIDTH+IW-1:TIME_WIDTH]),
      .rsp_segment_index (segment_index),
      .rsp_fraction      (fraction),
      .rsp_sample_time   (sample_time),
      .rsp_status        (status)
   );

   assign rsp_tdata = RSP_W'({status, sample_time, fraction, segment_index});

   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == kfrl_pkg::CMD_QUERY) |=> !req_tready)
      else $error("input still ready after a query was taken");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register loaded over a waiting item");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status == kfrl_pkg::STAT_RANGE)
         |-> (segment_index == '0 && fraction == '0 && sample_time == '0))
      else $error("index-too-large item carries nonzero fields");

   a_few_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status == kfrl_pkg::STAT_FEW)
         |-> (segment_index == '0 && fraction == '0))
      else $error("too-few-keys item carries a segment or fraction");

endmodule

// ----- rtl/kfrl_ram.sv -----
module kfrl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/kfrl_div.sv -----
module kfrl_div #(
   parameter int DVD_W = 48,
   parameter int DVS_W = 33,
   localparam int CNT_W = $clog2(DVD_W + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVS_W-1:0] rem_init,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   input  logic [CNT_W-1:0] steps,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             ge;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      ge     = trial >= {1'b0, dvs_ff};
      rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_in = {quo_ff[DVD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= rem_init;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/kfrl_dp.sv -----
module kfrl_dp #(
   parameter int MAX_KEYS   = kfrl_pkg::MAX_KEYS_DEF,
   parameter int TIME_WIDTH = kfrl_pkg::TIME_WIDTH_DEF,
   parameter int FRAC_BITS  = kfrl_pkg::FRAC_BITS_DEF,
   localparam int AW = $clog2(MAX_KEYS),
   localparam int IW = kfrl_pkg::INDEX_W,
   localparam int FW = FRAC_BITS + 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  kfrl_pkg::dp_cmd_type               cmd,
   output kfrl_pkg::dp_stat_type              stat,
   input  logic                               csr_write,
   input  logic [kfrl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [TIME_WIDTH-1:0]              csr_data,
   input  logic [TIME_WIDTH-1:0]              req_key_time,
   input  logic [IW-1:0]                      req_sample_index,
   output logic [AW-1:0]                      rsp_segment_index,
   output logic [FW-1:0]                      rsp_fraction,
   output logic [TIME_WIDTH-1:0]              rsp_sample_time,
   output logic [kfrl_pkg::STAT_W-1:0]        rsp_status
);

   localparam int TW    = TIME_WIDTH;
   localparam int KCW   = $clog2(MAX_KEYS + 1);
   localparam int DVD_W = TW + IW;
   localparam int DVS_W = TW + 1;
   localparam int CNT_W = $clog2(DVD_W + 1);
   localparam logic [FW-1:0] FRAC_ONE = FW'(1) << FRAC_BITS;

   logic signed [TW-1:0] start_ff, end_ff;
   logic [IW-1:0]        count_ff;
   logic [KCW-1:0]       key_count_ff;
   logic [IW-1:0]        idx_ff, n_m1_ff, n_m1_in;
   logic                 neg_ff;
   logic [TW-1:0]        mag_ff;
   logic [DVD_W-1:0]     prod_ff;
   logic signed [TW-1:0] t_ff;
   logic [KCW-1:0]       scan_ff;
   logic                 first_ff;
   logic signed [TW-1:0] prev_ff, left_ff, right_ff;
   logic [AW-1:0]        seg_ff;

   logic [AW-1:0]                 seg_out_ff, seg_out_in;
   logic [FW-1:0]                 frac_out_ff, frac_out_in;
   logic [TW-1:0]                 time_out_ff, time_out_in;
   logic [kfrl_pkg::STAT_W-1:0]   stat_out_ff, stat_out_in;

   logic [DVS_W-1:0] diff, mag_full;
   logic             key_full;
   logic             ram_we;
   logic [AW-1:0]    ram_raddr;
   logic [TW-1:0]    key_rdata;

   logic             div_start, div_done;
   logic [DVS_W-1:0] div_rem_init, div_dvs, div_rem;
   logic [DVD_W-1:0] div_dvd, div_quo;
   logic [CNT_W-1:0] div_steps;

   logic             rnd;
   logic [DVS_W-1:0] total, t_wide;
   logic [DVS_W-1:0] num, den;
   logic             lt, eq, full;

   always_comb begin
      diff     = {end_ff[TW-1], end_ff} - {start_ff[TW-1], start_ff};
      mag_full = diff[TW] ? (~diff + DVS_W'(1)) : diff;
      n_m1_in  = (count_ff < IW'(2)) ? IW'(1) : count_ff - IW'(1);
      key_full = key_count_ff == KCW'(MAX_KEYS);
      ram_we   = cmd.key_append && !key_full;
      ram_raddr = cmd.scan_first ? '0 : scan_ff[AW-1:0];
   end

   kfrl_ram #(
      .WIDTH (TW),
      .DEPTH (MAX_KEYS)
   ) u_keys (
      .clock (clock),
      .we    (ram_we),
      .waddr (key_count_ff[AW-1:0]),
      .wdata (req_key_time),
      .raddr (ram_raddr),
      .rdata (key_rdata)
   );

   // one unit for the sample time and the fraction
   always_comb begin
      num = {t_ff[TW-1], t_ff} - {left_ff[TW-1], left_ff};
      den = {right_ff[TW-1], right_ff} - {left_ff[TW-1], left_ff};
      lt   = t_ff < left_ff;
      eq   = right_ff == left_ff;
      full = num >= den;
      div_start = cmd.div_time || cmd.div_frac;
      if (cmd.div_frac) begin
         div_rem_init = num;
         div_dvd      = '0;
         div_dvs      = den;
         div_steps    = CNT_W'(FRAC_BITS);
      end else begin
         div_rem_init = '0;
         div_dvd      = prod_ff;
         div_dvs      = DVS_W'(n_m1_ff);
         div_steps    = CNT_W'(DVD_W);
      end
   end

   kfrl_div #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .rem_init  (div_rem_init),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .steps     (div_steps),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // round half away from zero on the magnitude
   always_comb begin
      rnd    = {div_rem, 1'b0} >= (DVS_W + 1)'(n_m1_ff);
      total  = {1'b0, div_quo[TW-1:0]} + DVS_W'(rnd);
      t_wide = neg_ff ? ({start_ff[TW-1], start_ff} - total)
                      : ({start_ff[TW-1], start_ff} + total);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         end_ff       <= TW'(kfrl_pkg::END_TIME_RESET);
         count_ff     <= kfrl_pkg::COUNT_RESET;
         key_count_ff <= '0;
         first_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               kfrl_pkg::REG_START_TIME:   start_ff <= csr_data;
               kfrl_pkg::REG_END_TIME:     end_ff   <= csr_data;
               kfrl_pkg::REG_OUTPUT_COUNT: count_ff <= csr_data[IW-1:0];
               default: ;
            endcase
         end
         if (cmd.key_clear) begin
            key_count_ff <= '0;
         end else if (ram_we) begin
            key_count_ff <= key_count_ff + KCW'(1);
         end
         if (cmd.scan_first) begin
            first_ff <= 1'b1;
         end else if (cmd.scan_step) begin
            first_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         idx_ff  <= req_sample_index;
         n_m1_ff <= n_m1_in;
         neg_ff  <= diff[TW];
         mag_ff  <= mag_full[TW-1:0];
      end
      if (cmd.mul_go) begin
         prod_ff <= DVD_W'(mag_ff) * DVD_W'(idx_ff);
      end
      if (cmd.time_go) begin
         t_ff <= t_wide[TW-1:0];
      end
      if (cmd.scan_first) begin
         scan_ff <= KCW'(1);
      end else if (cmd.scan_step) begin
         scan_ff  <= scan_ff + KCW'(1);
         prev_ff  <= key_rdata;
         left_ff  <= prev_ff;
         right_ff <= key_rdata;
         seg_ff   <= AW'(scan_ff - KCW'(2));
      end
      if (cmd.out_load) begin
         seg_out_ff  <= seg_out_in;
         frac_out_ff <= frac_out_in;
         time_out_ff <= time_out_in;
         stat_out_ff <= stat_out_in;
      end
   end

   always_comb begin
      seg_out_in  = '0;
      frac_out_in = '0;
      time_out_in = t_ff;
      stat_out_in = kfrl_pkg::STAT_OK;
      case (cmd.out_sel)
         kfrl_pkg::SEL_RANGE: begin
            time_out_in = '0;
            stat_out_in = kfrl_pkg::STAT_RANGE;
         end
         kfrl_pkg::SEL_FEW: begin
            stat_out_in = kfrl_pkg::STAT_FEW;
         end
         kfrl_pkg::SEL_ABOVE: begin
            seg_out_in  = AW'(key_count_ff - KCW'(2));
            frac_out_in = FRAC_ONE;
            stat_out_in = kfrl_pkg::STAT_CLAMP;
         end
         kfrl_pkg::SEL_FOUND: begin
            seg_out_in = seg_ff;
            if (lt) begin
               stat_out_in = kfrl_pkg::STAT_CLAMP;
            end else if (eq) begin
               stat_out_in = kfrl_pkg::STAT_ZERO_SEG;
            end else begin
               frac_out_in = FRAC_ONE;
            end
         end
         kfrl_pkg::SEL_DIV: begin
            seg_out_in  = seg_ff;
            frac_out_in = FW'(div_quo[FRAC_BITS-1:0]);
         end
         default: begin
            time_out_in = '0;
            stat_out_in = kfrl_pkg::STAT_RANGE;
         end
      endcase
   end

   always_comb begin
      stat.bad_index   = idx_ff > n_m1_ff;
      stat.few_keys    = key_count_ff < KCW'(2);
      stat.div_done    = div_done;
      stat.scan_found  = !first_ff && ($signed(key_rdata) >= t_ff);
      stat.scan_end    = !first_ff && (scan_ff == key_count_ff);
      stat.frac_direct = lt || eq || full;
   end

   assign rsp_segment_index = seg_out_ff;
   assign rsp_fraction      = frac_out_ff;
   assign rsp_sample_time   = time_out_ff;
   assign rsp_status        = stat_out_ff;

endmodule

// ----- rtl/kfrl_ctrl.sv -----
module kfrl_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [kfrl_pkg::CMD_W-1:0]    req_command,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output kfrl_pkg::dp_cmd_type          cmd,
   input  kfrl_pkg::dp_stat_type         stat
);

   kfrl_pkg::ctrl_state_type state_ff, state_in;
   kfrl_pkg::out_sel_type    sel_ff, sel_in;
   logic                     valid_ff, valid_in;
   logic                     accept;
   logic                     slot_free;

   assign accept    = req_valid && (state_ff == kfrl_pkg::S_IDLE);
   assign slot_free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kfrl_pkg::S_IDLE;
         sel_ff   <= kfrl_pkg::SEL_RANGE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      valid_in = valid_ff && !rsp_ready;
      case (state_ff)
         kfrl_pkg::S_IDLE: begin
            if (accept && req_command == kfrl_pkg::CMD_QUERY) begin
               state_in = kfrl_pkg::S_CHECK;
            end
         end
         kfrl_pkg::S_CHECK: begin
            if (stat.bad_index) begin
               sel_in   = kfrl_pkg::SEL_RANGE;
               state_in = kfrl_pkg::S_OUT;
            end else begin
               state_in = kfrl_pkg::S_TSTART;
            end
         end
         kfrl_pkg::S_TSTART: state_in = kfrl_pkg::S_DIV_T;
         kfrl_pkg::S_DIV_T: begin
            if (stat.div_done) begin
               state_in = kfrl_pkg::S_TIME;
            end
         end
         kfrl_pkg::S_TIME: begin
            if (stat.few_keys) begin
               sel_in   = kfrl_pkg::SEL_FEW;
               state_in = kfrl_pkg::S_OUT;
            end else begin
               state_in = kfrl_pkg::S_SCAN0;
            end
         end
         kfrl_pkg::S_SCAN0: state_in = kfrl_pkg::S_SCAN;
         kfrl_pkg::S_SCAN: begin
            if (stat.scan_found) begin
               state_in = kfrl_pkg::S_FCHK;
            end else if (stat.scan_end) begin
               sel_in   = kfrl_pkg::SEL_ABOVE;
               state_in = kfrl_pkg::S_OUT;
            end
         end
         kfrl_pkg::S_FCHK: begin
            if (stat.frac_direct) begin
               sel_in   = kfrl_pkg::SEL_FOUND;
               state_in = kfrl_pkg::S_OUT;
            end else begin
               state_in = kfrl_pkg::S_DIV_F;
            end
         end
         kfrl_pkg::S_DIV_F: begin
            if (stat.div_done) begin
               sel_in   = kfrl_pkg::SEL_DIV;
               state_in = kfrl_pkg::S_OUT;
            end
         end
         kfrl_pkg::S_OUT: begin
            if (slot_free) begin
               valid_in = 1'b1;
               state_in = kfrl_pkg::S_IDLE;
            end
         end
         default: state_in = kfrl_pkg::S_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd         = '0;
      cmd.out_sel = sel_ff;
      case (state_ff)
         kfrl_pkg::S_IDLE: begin
            cmd.key_clear  = accept && req_command == kfrl_pkg::CMD_CLEAR;
            cmd.key_append = accept && req_command == kfrl_pkg::CMD_APPEND;
            cmd.load_query = accept && req_command == kfrl_pkg::CMD_QUERY;
         end
         kfrl_pkg::S_CHECK:  cmd.mul_go     = !stat.bad_index;
         kfrl_pkg::S_TSTART: cmd.div_time   = 1'b1;
         kfrl_pkg::S_TIME:   cmd.time_go    = 1'b1;
         kfrl_pkg::S_SCAN0:  cmd.scan_first = 1'b1;
         kfrl_pkg::S_SCAN:   cmd.scan_step  = 1'b1;
         kfrl_pkg::S_FCHK:   cmd.div_frac   = !stat.frac_direct;
         kfrl_pkg::S_OUT:    cmd.out_load   = slot_free;
         default: ;
      endcase
   end

   assign req_ready = state_ff == kfrl_pkg::S_IDLE;
   assign rsp_valid = valid_ff;

endmodule
